### rtl/sph_pkg.sv
// Shared types and constants for the substring polynomial hash block.
// Used by sph_mulmod, substring_polynomial_hash and the testbench; depends on nothing.
`default_nettype none

package sph_pkg;

    // field widths of the transaction payloads
    localparam int HASH_W   = 61;
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int STATUS_W = 2;

    // modulus 2^61 - 1, also the 61-bit all-ones mask
    localparam logic [HASH_W-1:0] MOD_P = '1;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  left_index;
        logic [IDX_W-1:0]  right_index;
    } sph_req_t;

    typedef struct packed {
        logic [HASH_W-1:0]   hash_value;
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    stored_length;
    } sph_rsp_t;

endpackage

`default_nettype wire

### rtl/sph_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sph_ram #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/sph_mulmod.sv
// Iterative modular multiplier (a * b) mod 2^61-1 built on one 31x31 multiplier.
// Depends on sph_pkg.
`default_nettype none

module sph_mulmod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [sph_pkg::HASH_W-1:0]  op_a,
    input  wire logic [sph_pkg::HASH_W-1:0]  op_b,
    output logic                             done,
    output logic      [sph_pkg::HASH_W-1:0]  product
);

    localparam int LO_W   = 31;
    localparam int PROD_W = 2 * LO_W;
    localparam int ACC_W  = 2 * sph_pkg::HASH_W;

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_ACC,
        M_FOLD,
        M_SUB
    } mstate_t;

    mstate_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;

    logic [sph_pkg::HASH_W-1:0] a_reg, a_next;
    logic [sph_pkg::HASH_W-1:0] b_reg, b_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [1:0]                 sel_reg, sel_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [sph_pkg::HASH_W:0]   fold_reg, fold_next;
    logic [sph_pkg::HASH_W-1:0] product_reg, product_next;

    logic [LO_W-1:0]   op_x, op_y;
    logic [PROD_W-1:0] prod_full;
    logic [ACC_W-1:0]  acc_add;
    logic [sph_pkg::HASH_W:0] fold_minus;

    // partial product select: lo*lo, lo*hi, hi*lo, hi*hi
    assign op_x = cnt_reg[1] ? {1'b0, a_reg[sph_pkg::HASH_W-1:LO_W]} : a_reg[LO_W-1:0];
    assign op_y = cnt_reg[0] ? {1'b0, b_reg[sph_pkg::HASH_W-1:LO_W]} : b_reg[LO_W-1:0];
    assign prod_full = op_x * op_y;

    // align the registered partial product
    always_comb
    begin
        unique case (sel_reg)
            2'd0:    acc_add = ACC_W'(prod_reg);
            2'd3:    acc_add = ACC_W'(prod_reg) << (2 * LO_W);
            default: acc_add = ACC_W'(prod_reg) << LO_W;
        endcase
    end

    assign fold_minus = fold_reg - {1'b0, sph_pkg::MOD_P};

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        a_next       = a_reg;
        b_next       = b_reg;
        prod_next    = prod_reg;
        sel_next     = sel_reg;
        acc_next     = acc_reg;
        fold_next    = fold_reg;
        product_next = product_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    a_next     = op_a;
                    b_next     = op_b;
                    acc_next   = '0;
                    cnt_next   = 2'd0;
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                if (cnt_reg != 2'd0)
                begin
                    acc_next = acc_reg + acc_add;
                end
                prod_next = prod_full;
                sel_next  = cnt_reg;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = M_ACC;
                end
            end
            M_ACC:
            begin
                acc_next   = acc_reg + acc_add;
                state_next = M_FOLD;
            end
            M_FOLD:
            begin
                // 2^61 = 1 mod p
                fold_next = {1'b0, acc_reg[sph_pkg::HASH_W-1:0]}
                          + {1'b0, acc_reg[ACC_W-1:sph_pkg::HASH_W]};
                state_next = M_SUB;
            end
            M_SUB:
            begin
                if (fold_reg >= {1'b0, sph_pkg::MOD_P})
                begin
                    product_next = fold_minus[sph_pkg::HASH_W-1:0];
                end
                else
                begin
                    product_next = fold_reg[sph_pkg::HASH_W-1:0];
                end
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        prod_reg    <= prod_next;
        sel_reg     <= sel_next;
        acc_reg     <= acc_next;
        fold_reg    <= fold_next;
        product_reg <= product_next;
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

`default_nettype wire

### rtl/substring_polynomial_hash.sv
// Top level of the substring polynomial hash block.
// Depends on sph_pkg, sph_ram and sph_mulmod.
//
// Rolling hash mod 2^61-1 over a byte string of up to MAX_LEN bytes. A
// transaction is taken when start is high and busy is low; its one result
// appears on result for a single cycle with result_valid high and must be
// taken then, the receiver cannot stall it. An append runs a RAM read then
// two modular multiplies in turn; a substring query runs one multiply and a
// second prefix read; clear, unused kinds, a full store and a bad range
// answer in the next cycle. Each modular multiply runs on the shared 31x31
// multiplier. busy drops in the cycle the result is shown, so the next
// transaction can be taken there. hash_base is written through base_we and
// base_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. It applies to later appends only.
`default_nettype none

module substring_polynomial_hash #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire sph_pkg::sph_req_t          request,
    output logic                            result_valid,
    output sph_pkg::sph_rsp_t               result,
    input  wire logic                       base_we,
    input  wire logic [sph_pkg::HASH_W-1:0] base_wdata
);

    localparam int DEPTH = MAX_LEN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (AW > sph_pkg::IDX_W) ? AW : sph_pkg::IDX_W;
    localparam int HW    = sph_pkg::HASH_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_M1,
        S_APP_M2,
        S_QRY_RD,
        S_QRY_MUL,
        S_QRY_FIX
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   len_reg, len_next;
    logic [HW-1:0]   base_reg, base_next;
    logic            result_valid_reg, result_valid_next;

    sph_pkg::sph_rsp_t result_reg, result_next;
    logic [sph_pkg::CHAR_W-1:0] char_reg, char_next;
    logic            pz_reg, pz_next;
    logic            wz_reg, wz_next;
    logic            rz_reg, rz_next;
    logic [AW-1:0]   right_addr_reg, right_addr_next;
    logic [HW-1:0]   pw_reg, pw_next;
    logic [HW-1:0]   hash_reg, hash_next;
    logic [HW:0]     diff_reg, diff_next;

    // RAM ports
    logic            p_rd_en, w_rd_en, ram_we;
    logic [AW-1:0]   p_rd_addr, w_rd_addr, wr_addr;
    logic [HW-1:0]   p_rd_data, w_rd_data;

    // multiplier ports
    logic            mm_start, mm_done;
    logic [HW-1:0]   mm_a, mm_b, mm_product;

    // index arithmetic in a common width
    logic [CW-1:0]   left_ext, right_ext, len_ext, span_ext, len_out_ext;
    logic [HW-1:0]   prefix_val, power_val, right_val;
    logic [HW:0]     app_sum, app_sum_minus;
    logic [HW-1:0]   fix_val;

    assign left_ext    = CW'(request.left_index);
    assign right_ext   = CW'(request.right_index);
    assign len_ext     = CW'(len_reg);
    assign span_ext    = right_ext - left_ext;
    assign len_out_ext = CW'(len_next);

    // entry zero is never written: prefix 0 is zero, power 0 is one
    assign prefix_val = pz_reg ? '0 : p_rd_data;
    assign power_val  = wz_reg ? HW'(1) : w_rd_data;
    assign right_val  = rz_reg ? '0 : p_rd_data;

    // append: multiply result plus byte, then one conditional subtract
    assign app_sum       = {1'b0, mm_product} + (HW + 1)'(char_reg);
    assign app_sum_minus = app_sum - {1'b0, sph_pkg::MOD_P};

    // query: wrap the difference back into range
    assign fix_val = diff_reg[HW] ? (diff_reg[HW-1:0] + sph_pkg::MOD_P) : diff_reg[HW-1:0];

    assign wr_addr = len_reg + AW'(1);

    sph_ram #(
        .WIDTH(HW),
        .DEPTH(DEPTH)
    ) u_prefix_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (hash_reg),
        .rd_en   (p_rd_en),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd_data)
    );

    sph_ram #(
        .WIDTH(HW),
        .DEPTH(DEPTH)
    ) u_power_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (mm_product),
        .rd_en   (w_rd_en),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    sph_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .done    (mm_done),
        .product (mm_product)
    );

    // sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        len_next          = len_reg;
        base_next         = base_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        char_next         = char_reg;
        pz_next           = pz_reg;
        wz_next           = wz_reg;
        rz_next           = rz_reg;
        right_addr_next   = right_addr_reg;
        pw_next           = pw_reg;
        hash_next         = hash_reg;
        diff_next         = diff_reg;
        p_rd_en           = 1'b0;
        w_rd_en           = 1'b0;
        p_rd_addr         = len_reg;
        w_rd_addr         = len_reg;
        ram_we            = 1'b0;
        mm_start          = 1'b0;
        mm_a              = prefix_val;
        mm_b              = base_reg;

        // base register, reduced on write so the modulus acts as zero
        if (base_we)
        begin
            base_next = (base_wdata == sph_pkg::MOD_P) ? '0 : base_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    result_next.hash_value = '0;
                    result_next.status     = sph_pkg::STATUS_OK;
                    unique case (request.kind)
                        sph_pkg::KIND_APPEND:
                        begin
                            if (len_reg == AW'(MAX_LEN))
                            begin
                                result_next.status = sph_pkg::STATUS_FULL;
                                result_valid_next  = 1'b1;
                            end
                            else
                            begin
                                p_rd_en    = 1'b1;
                                w_rd_en    = 1'b1;
                                pz_next    = (len_reg == '0);
                                wz_next    = (len_reg == '0);
                                char_next  = request.char_code;
                                state_next = S_APP_RD;
                            end
                        end
                        sph_pkg::KIND_QUERY:
                        begin
                            if ((left_ext > right_ext) || (right_ext > len_ext))
                            begin
                                result_next.status = sph_pkg::STATUS_RANGE;
                                result_valid_next  = 1'b1;
                            end
                            else
                            begin
                                p_rd_en         = 1'b1;
                                w_rd_en         = 1'b1;
                                p_rd_addr       = left_ext[AW-1:0];
                                w_rd_addr       = span_ext[AW-1:0];
                                pz_next         = (left_ext == '0);
                                wz_next         = (span_ext == '0);
                                rz_next         = (right_ext == '0);
                                right_addr_next = right_ext[AW-1:0];
                                state_next      = S_QRY_RD;
                            end
                        end
                        sph_pkg::KIND_CLEAR:
                        begin
                            len_next          = '0;
                            result_valid_next = 1'b1;
                        end
                        default:
                        begin
                            result_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_APP_RD:
            begin
                // new prefix = prefix * base, power saved for the second multiply
                mm_start   = 1'b1;
                mm_a       = prefix_val;
                mm_b       = base_reg;
                pw_next    = power_val;
                state_next = S_APP_M1;
            end
            S_APP_M1:
            begin
                if (mm_done)
                begin
                    if (app_sum >= {1'b0, sph_pkg::MOD_P})
                    begin
                        hash_next = app_sum_minus[HW-1:0];
                    end
                    else
                    begin
                        hash_next = app_sum[HW-1:0];
                    end
                    mm_start   = 1'b1;
                    mm_a       = pw_reg;
                    mm_b       = base_reg;
                    state_next = S_APP_M2;
                end
            end
            S_APP_M2:
            begin
                if (mm_done)
                begin
                    ram_we                 = 1'b1;
                    len_next               = len_reg + AW'(1);
                    result_next.hash_value = hash_reg;
                    result_next.status     = sph_pkg::STATUS_OK;
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            S_QRY_RD:
            begin
                // multiply prefix[left] by power[span], fetch prefix[right]
                mm_start   = 1'b1;
                mm_a       = prefix_val;
                mm_b       = power_val;
                p_rd_en    = 1'b1;
                p_rd_addr  = right_addr_reg;
                pz_next    = rz_reg;
                state_next = S_QRY_MUL;
            end
            S_QRY_MUL:
            begin
                if (mm_done)
                begin
                    diff_next  = {1'b0, right_val} - {1'b0, mm_product};
                    state_next = S_QRY_FIX;
                end
            end
            S_QRY_FIX:
            begin
                result_next.hash_value = fix_val;
                result_next.status     = sph_pkg::STATUS_OK;
                result_valid_next      = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_next.stored_length = len_out_ext[sph_pkg::IDX_W-1:0];
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            len_reg          <= '0;
            base_reg         <= HW'(131);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            base_reg         <= base_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        char_reg       <= char_next;
        pz_reg         <= pz_next;
        wz_reg         <= wz_next;
        rz_reg         <= rz_next;
        right_addr_reg <= right_addr_next;
        pw_reg         <= pw_next;
        hash_reg       <= hash_next;
        diff_reg       <= diff_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### dv/substring_polynomial_hash_tb.sv
// Self-checking testbench for substring_polynomial_hash: directed and random
// transactions are checked against a rolling-hash predictor kept in this file.
// Depends on sph_pkg and the substring_polynomial_hash RTL.

module substring_polynomial_hash_tb;

    localparam int FULL_LEN = 1024;
    localparam logic [sph_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_PCT = 34;
    localparam int MAX_SHOWN = 10;
    localparam int ITEMS_PER_PHASE = 15;
    localparam int NO_IDLE_LEN = 256;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    sph_pkg::sph_req_t request;
    logic result_valid;
    sph_pkg::sph_rsp_t result;
    logic base_we;
    logic [sph_pkg::HASH_W-1:0] base_wdata;

    // predictor state: prefix hashes, base powers, length and base
    logic [sph_pkg::HASH_W-1:0] shadow_prefix [0:FULL_LEN];
    logic [sph_pkg::HASH_W-1:0] shadow_power [0:FULL_LEN];
    int unsigned shadow_length;
    logic [sph_pkg::HASH_W-1:0] shadow_base;

    sph_pkg::sph_rsp_t pending_results [$];
    int mismatch_count;
    bit idle_enabled;
    sph_pkg::sph_rsp_t oldest;

    substring_polynomial_hash #(
        .MAX_LEN(FULL_LEN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .base_we      (base_we),
        .base_wdata   (base_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // (a * b) mod 2^61-1 on the full 122-bit product
    function automatic logic [sph_pkg::HASH_W-1:0] mul_mod_p(
        input logic [sph_pkg::HASH_W-1:0] a,
        input logic [sph_pkg::HASH_W-1:0] b);
        logic [2*sph_pkg::HASH_W-1:0] prod;
        logic [sph_pkg::HASH_W:0] folded;
        logic [sph_pkg::HASH_W:0] reduced;
        prod = {{sph_pkg::HASH_W{1'b0}}, a} * {{sph_pkg::HASH_W{1'b0}}, b};
        folded = {1'b0, prod[sph_pkg::HASH_W-1:0]}
                 + {1'b0, prod[2*sph_pkg::HASH_W-1:sph_pkg::HASH_W]};
        reduced = {1'b0, folded[sph_pkg::HASH_W-1:0]} + folded[sph_pkg::HASH_W];
        if (reduced >= {1'b0, sph_pkg::MOD_P})
            reduced = reduced - {1'b0, sph_pkg::MOD_P};
        return reduced[sph_pkg::HASH_W-1:0];
    endfunction

    // expected result of one transaction, updating the predictor state
    task automatic predict_hash_result(input sph_pkg::sph_req_t req,
                                       output sph_pkg::sph_rsp_t rsp);
        logic [sph_pkg::HASH_W-1:0] eff_base;
        logic [sph_pkg::HASH_W-1:0] sub;
        logic [sph_pkg::HASH_W:0] acc;
        int unsigned lo;
        int unsigned hi;
        rsp = '0;
        lo = req.left_index;
        hi = req.right_index;
        eff_base = (shadow_base == sph_pkg::MOD_P) ? '0 : shadow_base;
        if (req.kind == sph_pkg::KIND_APPEND)
        begin
            if (shadow_length >= FULL_LEN)
                rsp.status = sph_pkg::STATUS_FULL;
            else
            begin
                acc = {1'b0, mul_mod_p(shadow_prefix[shadow_length], eff_base)}
                      + req.char_code;
                if (acc >= {1'b0, sph_pkg::MOD_P})
                    acc = acc - {1'b0, sph_pkg::MOD_P};
                rsp.hash_value = acc[sph_pkg::HASH_W-1:0];
                shadow_prefix[shadow_length + 1] = acc[sph_pkg::HASH_W-1:0];
                shadow_power[shadow_length + 1] =
                    mul_mod_p(shadow_power[shadow_length], eff_base);
                shadow_length = shadow_length + 1;
            end
        end
        else if (req.kind == sph_pkg::KIND_QUERY)
        begin
            if (lo > hi || hi > shadow_length)
                rsp.status = sph_pkg::STATUS_RANGE;
            else
            begin
                sub = mul_mod_p(shadow_prefix[lo], shadow_power[hi - lo]);
                acc = {1'b0, shadow_prefix[hi]} + {1'b0, sph_pkg::MOD_P} - {1'b0, sub};
                if (acc >= {1'b0, sph_pkg::MOD_P})
                    acc = acc - {1'b0, sph_pkg::MOD_P};
                rsp.hash_value = acc[sph_pkg::HASH_W-1:0];
            end
        end
        else if (req.kind == sph_pkg::KIND_CLEAR)
            shadow_length = 0;
        rsp.stored_length = shadow_length[sph_pkg::IDX_W-1:0];
    endtask

    function automatic sph_pkg::sph_req_t make_req(input logic [sph_pkg::KIND_W-1:0] kind,
                                                   input int code, input int lo,
                                                   input int hi);
        sph_pkg::sph_req_t req;
        req.kind = kind;
        req.char_code = code[sph_pkg::CHAR_W-1:0];
        req.left_index = lo[sph_pkg::IDX_W-1:0];
        req.right_index = hi[sph_pkg::IDX_W-1:0];
        return req;
    endfunction

    // random transaction, mostly well-formed against the current length
    function automatic sph_pkg::sph_req_t random_request();
        logic [sph_pkg::KIND_W-1:0] kind;
        int unsigned pick;
        int unsigned code;
        int unsigned lo;
        int unsigned hi;
        pick = $urandom_range(99);
        kind = sph_pkg::KIND_APPEND;
        code = $urandom_range(255);
        lo = $urandom_range(2047);
        hi = $urandom_range(2047);
        if (pick >= 50 && pick < 80)
        begin
            kind = sph_pkg::KIND_QUERY;
            hi = $urandom_range(shadow_length);
            lo = $urandom_range(hi);
        end
        else if (pick >= 80 && pick < 88)
        begin
            kind = sph_pkg::KIND_QUERY;
            if ($urandom_range(1) == 0)
            begin
                hi = $urandom_range(2046);
                lo = $urandom_range(2047, hi + 1);
            end
            else if (shadow_length < 2047)
            begin
                hi = $urandom_range(2047, shadow_length + 1);
                lo = $urandom_range(hi);
            end
        end
        else if (pick == 88)
            kind = sph_pkg::KIND_CLEAR;
        else if (pick >= 89 && pick < 92)
            kind = KIND_UNUSED;
        return make_req(kind, code, lo, hi);
    endfunction

    // one transaction: start idles at random per cycle, when idling is enabled, until accepted
    task automatic send_request(input sph_pkg::sph_req_t req);
        sph_pkg::sph_rsp_t want;
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            request <= req;
            if (idle_enabled && $urandom_range(99) < IDLE_PCT)
                start <= 1'b0;
            else
                start <= 1'b1;
            @(posedge clk);
            taken = start && !busy;
        end
        predict_hash_result(req, want);
        pending_results.push_back(want);
    endtask

    // wait until every expected result has come and the block is idle
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_hash_base(input logic [sph_pkg::HASH_W-1:0] value);
        drain();
        @(negedge clk);
        base_we <= 1'b1;
        base_wdata <= value;
        @(negedge clk);
        base_we <= 1'b0;
        shadow_base = value;
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // result checker, one transaction per strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result, hash", 64'd0, 64'(result.hash_value));
            else
            begin
                oldest = pending_results.pop_front();
                if (result.hash_value !== oldest.hash_value)
                    note_mismatch("hash_value", 64'(oldest.hash_value),
                                  64'(result.hash_value));
                if (result.status !== oldest.status)
                    note_mismatch("status", 64'(oldest.status), 64'(result.status));
                if (result.stored_length !== oldest.stored_length)
                    note_mismatch("stored_length", 64'(oldest.stored_length),
                                  64'(result.stored_length));
            end
        end
    end

    // field extremes, every kind, empty and bad ranges, clear, unused kind
    task automatic test_directed_edges();
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, 0));
        send_request(make_req(sph_pkg::KIND_APPEND, 0, 0, 0));
        send_request(make_req(sph_pkg::KIND_APPEND, 255, 2047, 2047));
        send_request(make_req(sph_pkg::KIND_APPEND, 8'h5a, 0, 0));
        send_request(make_req(sph_pkg::KIND_APPEND, 8'ha5, 0, 0));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, 4));
        send_request(make_req(sph_pkg::KIND_QUERY, 255, 1, 3));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 4, 4));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 3, 1));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, 5));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 2047, 2047));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, 2047));
        send_request(make_req(KIND_UNUSED, 255, 2047, 2047));
        send_request(make_req(sph_pkg::KIND_CLEAR, 255, 2047, 2047));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, 0));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, 1));
        send_request(make_req(sph_pkg::KIND_APPEND, 1, 0, 0));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, 1));
        drain();
    endtask

    // fill the store, append once more, then query at full length;
    // the start of the fill runs with no idling at all
    task automatic test_store_full();
        send_request(make_req(sph_pkg::KIND_CLEAR, 0, 0, 0));
        idle_enabled = 1'b0;
        while (shadow_length < FULL_LEN)
        begin
            if (shadow_length >= NO_IDLE_LEN)
                idle_enabled = 1'b1;
            send_request(make_req(sph_pkg::KIND_APPEND, $urandom_range(255), 0, 0));
        end
        idle_enabled = 1'b1;
        send_request(make_req(sph_pkg::KIND_APPEND, 8'h33, 0, 0));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, FULL_LEN));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, FULL_LEN - 1, FULL_LEN));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, FULL_LEN, FULL_LEN));
        send_request(make_req(sph_pkg::KIND_QUERY, 0, 5, FULL_LEN + 1));
        send_request(make_req(sph_pkg::KIND_APPEND, 8'hff, 0, 0));
        send_request(make_req(sph_pkg::KIND_CLEAR, 0, 0, 0));
        drain();
    endtask

    // base extremes; a new base only affects later appends
    task automatic test_base_change();
        logic [sph_pkg::HASH_W-1:0] bases [5];
        bases[0] = '0;
        bases[1] = sph_pkg::MOD_P;
        bases[2] = sph_pkg::MOD_P - 1;
        bases[3] = 1;
        bases[4] = 131;
        for (int k = 0; k < 5; k++)
        begin
            write_hash_base(bases[k]);
            send_request(make_req(sph_pkg::KIND_APPEND, $urandom_range(255), 0, 0));
            send_request(make_req(sph_pkg::KIND_APPEND, 255, 0, 0));
            send_request(make_req(sph_pkg::KIND_QUERY, 0, 0, shadow_length));
            send_request(make_req(sph_pkg::KIND_QUERY, 0, 1, shadow_length));
        end
        drain();
    endtask

    // random traffic in phases, each with its own base; one phase never idles
    task automatic test_random_traffic();
        logic [sph_pkg::HASH_W-1:0] phase_base;
        logic [63:0] rnd;
        for (int phase = 0; phase < 6; phase++)
        begin
            rnd = {$urandom, $urandom};
            case (phase)
                1: phase_base = sph_pkg::MOD_P - 1;
                2: phase_base = 2;
                4: phase_base = sph_pkg::MOD_P;
                default: phase_base = rnd[sph_pkg::HASH_W-1:0];
            endcase
            write_hash_base(phase_base);
            idle_enabled = (phase != 3);
            repeat (ITEMS_PER_PHASE)
                send_request(random_request());
        end
        idle_enabled = 1'b1;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        base_we = 1'b0;
        base_wdata = '0;
        mismatch_count = 0;
        idle_enabled = 1'b1;
        shadow_prefix[0] = '0;
        shadow_power[0] = 1;
        shadow_length = 0;
        shadow_base = 131;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_store_full();
        test_base_change();
        test_random_traffic();

        // late or extra results
        repeat (30) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch("missing results, count", 64'd0, 64'(pending_results.size()));
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
